### rtl/smc_pkg.sv
package smc_pkg;

  // main mode codes
  localparam logic [2:0] MODE_OPENING = 3'd0;
  localparam logic [2:0] MODE_CLOSING = 3'd1;
  localparam logic [2:0] MODE_STOPPED = 3'd2;
  localparam logic [2:0] MODE_OPENED  = 3'd3;
  localparam logic [2:0] MODE_CLOSED  = 3'd4;

  // auxiliary mode codes
  localparam logic [1:0] AUX_STOPPED = 2'd0;
  localparam logic [1:0] AUX_OPENED  = 2'd1;
  localparam logic [1:0] AUX_CLOSED  = 2'd2;

  // drive codes
  localparam logic [1:0] DRIVE_OFF   = 2'd0;
  localparam logic [1:0] DRIVE_OPEN  = 2'd1;
  localparam logic [1:0] DRIVE_CLOSE = 2'd2;

  // operation codes
  localparam logic [1:0] OP_OPEN  = 2'd0;
  localparam logic [1:0] OP_CLOSE = 2'd1;
  localparam logic [1:0] OP_STOP  = 2'd2;
  localparam logic [1:0] OP_CHECK = 2'd3;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] REG_OPEN_TIME      = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_MAX_CLOSE_TIME = 2'd1;

  localparam logic [31:0] OpenTimeReset     = 32'd15000;
  localparam logic [31:0] MaxCloseTimeReset = 32'd25000;

  typedef struct packed {
    logic [2:0]  main_mode;
    logic [1:0]  aux_mode;
    logic [31:0] start_stamp;
    logic        timeout_error;
    logic [1:0]  drive;
  } ctrl_state_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] now_ms;
    logic [2:0]  closed_samples;
    logic [2:0]  aux_samples;
  } cmd_t;

  localparam ctrl_state_t StateReset = '{
    main_mode:     MODE_STOPPED,
    aux_mode:      AUX_STOPPED,
    start_stamp:   32'd0,
    timeout_error: 1'b0,
    drive:         DRIVE_OFF
  };

endpackage

### rtl/smc_step.sv
module smc_step (
  input  smc_pkg::cmd_t       cmd_i,
  input  smc_pkg::ctrl_state_t state_i,
  input  logic [31:0]          open_time_i,
  input  logic [31:0]          max_close_time_i,
  output smc_pkg::ctrl_state_t state_o,
  output logic                 timed_out_o
);
  import smc_pkg::*;

  logic        limit_now;
  logic        close_ok;
  logic [31:0] elapsed;

  assign limit_now = ~cmd_i.closed_samples[0];
  assign close_ok  = (state_i.main_mode == MODE_OPENED) ||
                     (state_i.main_mode == MODE_OPENING) ||
                     (state_i.main_mode == MODE_STOPPED);
  // wrapping difference
  assign elapsed   = cmd_i.now_ms - state_i.start_stamp;

  always_comb begin
    state_o     = state_i;
    timed_out_o = 1'b0;
    case (cmd_i.operation)
      OP_OPEN: begin
        if (limit_now || state_i.main_mode == MODE_CLOSING) begin
          state_o.drive       = DRIVE_OPEN;
          state_o.start_stamp = cmd_i.now_ms;
          state_o.main_mode   = MODE_OPENING;
        end else if (state_i.main_mode != MODE_OPENING) begin
          state_o.main_mode = MODE_STOPPED;
        end
      end
      OP_CLOSE: begin
        if (close_ok && !limit_now) begin
          state_o.drive       = DRIVE_CLOSE;
          state_o.start_stamp = cmd_i.now_ms;
          state_o.main_mode   = MODE_CLOSING;
        end else if (state_i.main_mode != MODE_CLOSING) begin
          state_o.main_mode = MODE_STOPPED;
        end
      end
      OP_STOP: begin
        state_o.drive       = DRIVE_OFF;
        state_o.start_stamp = 32'd0;
      end
      default: begin
        if (state_i.main_mode == MODE_OPENING) begin
          if (elapsed > open_time_i) begin
            state_o.drive       = DRIVE_OFF;
            state_o.start_stamp = 32'd0;
            state_o.main_mode   = MODE_OPENED;
          end
        end else if (state_i.main_mode == MODE_CLOSING) begin
          if (elapsed > max_close_time_i) begin
            state_o.drive         = DRIVE_OFF;
            state_o.start_stamp   = 32'd0;
            state_o.timeout_error = 1'b1;
            timed_out_o           = 1'b1;
          end else if (cmd_i.closed_samples == 3'b000) begin
            state_o.drive       = DRIVE_OFF;
            state_o.start_stamp = 32'd0;
            state_o.main_mode   = MODE_CLOSED;
          end
        end
        state_o.aux_mode = (cmd_i.aux_samples == 3'b000) ? AUX_OPENED : AUX_CLOSED;
      end
    endcase
  end

endmodule

### rtl/shutter_motor_controller_core.sv
// Shutter motor controller. Each input beat carries one operation (open,
// close, stop or check) with a millisecond timestamp and the closed-limit and
// auxiliary sensor samples; each accepted beat yields exactly one result beat
// with the drive direction, main and auxiliary condition, the sticky timeout
// flag and whether this check timed out. An accepted beat passes through one
// input register, then the decision logic (one 32-bit subtract and compare
// against open_time or max_close_time) feeding the result register, where
// the controller state is also updated.
// Throughput is one beat per clock; the input side keeps accepting while a
// result waits, and stalls only when both the input register and the result
// register are full and the result beat is stalled. Registers open_time
// (index 0, reset 15000) and
// max_close_time (index 1, reset 25000) are written through the config port,
// which is always ready; writes to other indexes are dropped. Write them only
// while no beat is in flight.
module shutter_motor_controller_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // config write channel
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [smc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [31:0]                  cfg_data_i,
  // input channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   operation_i,
  input  logic [31:0]                  now_ms_i,
  input  logic [2:0]                   closed_samples_i,
  input  logic [2:0]                   aux_samples_i,
  // result channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   motor_drive_o,
  output logic [2:0]                   main_condition_o,
  output logic [1:0]                   aux_condition_o,
  output logic                         error_flag_o,
  output logic                         check_timed_out_o
);
  import smc_pkg::*;

  // config registers
  logic [31:0] open_time_q;
  logic [31:0] max_close_time_q;

  // input register
  logic        in_valid_q;
  cmd_t        cmd_q;

  // controller state
  ctrl_state_t state_q, state_d;
  logic        timed_out_d;

  // result register
  logic        out_valid_q;
  ctrl_state_t res_q;
  logic        res_timed_out_q;

  logic        out_load;
  logic        in_take;

  // result register can load when empty or being drained
  assign out_load   = !out_valid_q || !out_stall_i;
  assign in_take    = in_valid_i && !in_stall_o;
  assign in_stall_o = in_valid_q && !out_load;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_time_q      <= OpenTimeReset;
      max_close_time_q <= MaxCloseTimeReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_OPEN_TIME:      open_time_q      <= cfg_data_i;
        REG_MAX_CLOSE_TIME: max_close_time_q <= cfg_data_i;
        default: ;  // unknown index, dropped
      endcase
    end
  end

  // input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (out_load || !in_valid_q) begin
      in_valid_q <= in_take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cmd_q <= '{operation:      operation_i,
                 now_ms:         now_ms_i,
                 closed_samples: closed_samples_i,
                 aux_samples:    aux_samples_i};
    end
  end

  smc_step u_step (
    .cmd_i            (cmd_q),
    .state_i          (state_q),
    .open_time_i      (open_time_q),
    .max_close_time_i (max_close_time_q),
    .state_o          (state_d),
    .timed_out_o      (timed_out_d)
  );

  // state commits as the beat moves into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateReset;
    end else if (in_valid_q && out_load) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_q && out_load) begin
      res_q           <= state_d;
      res_timed_out_q <= timed_out_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign motor_drive_o     = res_q.drive;
  assign main_condition_o  = res_q.main_mode;
  assign aux_condition_o   = res_q.aux_mode;
  assign error_flag_o      = res_q.timeout_error;
  assign check_timed_out_o = res_timed_out_q;

endmodule

### rtl/smc_checker.sv
module smc_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [1:0]                  motor_drive_o,
  input logic [2:0]                  main_condition_o,
  input logic                        error_flag_o,
  input logic                        check_timed_out_o
);
  import smc_pkg::*;

  // stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // a timed-out check leaves the drive off, mode closing, flag set
  a_timeout_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && check_timed_out_o |->
      error_flag_o && motor_drive_o == DRIVE_OFF && main_condition_o == MODE_CLOSING)
    else $error("timeout result inconsistent");

  // end positions are only reached with the drive halted
  a_rest_drive_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (main_condition_o == MODE_OPENED || main_condition_o == MODE_CLOSED)
      |-> motor_drive_o == DRIVE_OFF)
    else $error("drive on at an end position");

  // error flag never clears once delivered
  a_error_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && error_flag_o |=> !out_valid_o || error_flag_o)
    else $error("error flag cleared");

endmodule

bind shutter_motor_controller_core smc_checker u_smc_checker (.*);
